### rtl/rsa_modexp_engine_macros.svh
// Assertion macros shared by the modular exponentiation RTL.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef RSA_MODEXP_ENGINE_MACROS_SVH
`define RSA_MODEXP_ENGINE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RSA_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RSA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/rsa_pkg.sv
// Package for the modular exponentiation engine: widths, register indexes,
// reset values, sequencer states and the multiplier request/status structs.
// No dependencies.
package rsa_pkg;

  localparam int MOD_BITS = 32;
  localparam int EXP_BITS = 32;
  localparam int CNT_W    = $clog2(MOD_BITS + 1);

  typedef logic [MOD_BITS-1:0] mod_word_t;
  typedef logic [EXP_BITS-1:0] exp_word_t;
  typedef logic [1:0]          cfg_idx_t;

  // Configuration register indexes.
  localparam cfg_idx_t CFG_PUBLIC_EXP  = 2'd0;
  localparam cfg_idx_t CFG_PRIVATE_EXP = 2'd1;
  localparam cfg_idx_t CFG_MODULUS     = 2'd2;

  // Command codes.
  localparam logic CMD_ENCRYPT = 1'b0;
  localparam logic CMD_DECRYPT = 1'b1;

  localparam exp_word_t PUBLIC_EXP_RST  = EXP_BITS'(5);
  localparam exp_word_t PRIVATE_EXP_RST = EXP_BITS'(167741);
  localparam mod_word_t MODULUS_RST     = MOD_BITS'(840551);

  localparam mod_word_t MOD_ONE = MOD_BITS'(1);
  localparam mod_word_t MOD_TWO = MOD_BITS'(2);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_STEP,
    ST_MUL,
    ST_SQR,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic      start;
    mod_word_t a;
    mod_word_t b;
  } mm_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mm_status_t;

endpackage

### rtl/rsa_modexp_engine.sv
// Top level of the modular exponentiation engine: configuration registers,
// square-and-multiply sequencer and output register.
// Depends on rsa_pkg, rsa_modmul and rsa_modexp_engine_macros.svh.
//
// Usage:
//   Input channel (in_valid, in_stall, cmd, value): a word is taken when
//   in_valid is high and in_stall is low. cmd 0 raises value to the public
//   exponent, cmd 1 to the private exponent, both modulo key modulus.
//   Output channel (out_valid, out_stall, residue): one word per input word.
//   The result sits in an output register; while the receiver holds
//   out_stall high the word stays unchanged and the engine may already take
//   and work on the next input, holding its finished result until the
//   output register empties.
//   Configuration (cfg_valid, cfg_ready, cfg_index, cfg_data): index 0 is the
//   public exponent, 1 the private exponent, 2 the modulus. cfg_ready is
//   always high; write only while the engine is idle.
//   Sequencing: the engine takes one word at a time. The bit-serial modular
//   multiplier forms each product. One reduction of the value comes first,
//   then for each exponent bit up to the highest set one a square and, for
//   a set bit, a multiply, each bit first examined by the sequencer in
//   ST_STEP. A modulus below two gives 0 without using the multiplier.
//   Reset (rst, synchronous) restores the default key and empties the
//   output register.
`include "rsa_modexp_engine_macros.svh"

module rsa_modexp_engine
  import rsa_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  logic      cmd,
  input  logic [31:0] value,
  output logic      out_valid,
  input  logic      out_stall,
  output logic [31:0] residue,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  cfg_idx_t  cfg_index,
  input  logic [31:0] cfg_data
);

  // Configuration registers.
  exp_word_t public_exponent;
  exp_word_t private_exponent;
  mod_word_t key_modulus;

  // Sequencer and working registers.
  state_t    state;
  state_t    state_next;
  exp_word_t exp_r;
  mod_word_t acc_r;
  mod_word_t base_r;
  mod_word_t m_r;

  mm_req_t    mm_req;
  mm_status_t mm_stat;
  mod_word_t  mm_product;

  logic in_accept;
  logic out_free;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      public_exponent  <= PUBLIC_EXP_RST;
      private_exponent <= PRIVATE_EXP_RST;
      key_modulus      <= MODULUS_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_PUBLIC_EXP:  public_exponent  <= cfg_data;
        CFG_PRIVATE_EXP: private_exponent <= cfg_data;
        CFG_MODULUS:     key_modulus      <= cfg_data;
        default: ;
      endcase
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_accept) begin
          state_next = (key_modulus < MOD_TWO) ? ST_FINISH : ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        if (mm_stat.done) begin
          state_next = ST_STEP;
        end
      end
      ST_STEP: begin
        if (exp_r == '0) begin
          state_next = ST_FINISH;
        end else if (exp_r[0]) begin
          state_next = ST_MUL;
        end else begin
          state_next = ST_SQR;
        end
      end
      ST_MUL: begin
        if (mm_stat.done) begin
          state_next = ST_SQR;
        end
      end
      ST_SQR: begin
        if (mm_stat.done) begin
          state_next = ST_STEP;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Multiplier requests. The value is reduced as the product 1 * value.
  always_comb begin
    mm_req = '0;
    case (state)
      ST_IDLE: begin
        mm_req.start = in_accept && (key_modulus >= MOD_TWO);
        mm_req.a     = MOD_ONE;
        mm_req.b     = value;
      end
      ST_STEP: begin
        mm_req.start = (exp_r != '0);
        mm_req.a     = exp_r[0] ? acc_r : base_r;
        mm_req.b     = base_r;
      end
      ST_MUL: begin
        mm_req.start = mm_stat.done;
        mm_req.a     = base_r;
        mm_req.b     = base_r;
      end
      default: mm_req = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_accept) begin
          m_r   <= key_modulus;
          exp_r <= (cmd == CMD_DECRYPT) ? private_exponent : public_exponent;
          acc_r <= '0;
        end
      end
      ST_REDUCE: begin
        if (mm_stat.done) begin
          base_r <= mm_product;
          acc_r  <= MOD_ONE;
        end
      end
      ST_MUL: begin
        if (mm_stat.done) begin
          acc_r <= mm_product;
        end
      end
      ST_SQR: begin
        if (mm_stat.done) begin
          base_r <= mm_product;
          exp_r  <= exp_r >> 1;
        end
      end
      default: ;
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_FINISH && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FINISH && out_free) begin
      residue <= acc_r;
    end
  end

  rsa_modmul u_modmul (
    .clk     (clk),
    .rst     (rst),
    .req     (mm_req),
    .modulus (m_r),
    .stat    (mm_stat),
    .product (mm_product)
  );

  `RSA_ASSERT_NEXT(a_busy_after_accept, in_accept, in_stall,
    "engine did not go busy after taking a word")
  `RSA_ASSERT_SAME(a_done_while_waiting, mm_stat.done,
    state == ST_REDUCE || state == ST_MUL || state == ST_SQR,
    "multiplier finished while the sequencer was not waiting on it")
  `RSA_ASSERT_SAME(a_unit_idle_at_step, state == ST_STEP, !mm_stat.busy,
    "multiplier still busy when the next exponent bit is examined")
  `RSA_ASSERT_SAME(a_operands_reduced, state == ST_STEP,
    acc_r < m_r && base_r < m_r,
    "working operands not reduced below the modulus")

endmodule

### rtl/rsa_modmul.sv
// Bit-serial modular multiplier: one bit of the multiplier per cycle,
// doubling and conditional add, each reduced by one compare and subtract.
// Depends on rsa_pkg.
module rsa_modmul
  import rsa_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  mm_req_t    req,
  input  mod_word_t  modulus,
  output mm_status_t stat,
  output mod_word_t  product
);

  mod_word_t        acc;
  mod_word_t        a_r;
  mod_word_t        b_r;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             done;

  logic [MOD_BITS:0] dbl;
  logic [MOD_BITS:0] dbl_red;
  logic [MOD_BITS:0] sum;
  logic [MOD_BITS:0] sum_red;
  logic [MOD_BITS:0] mod_ext;

  // Operands stay below the modulus, so each partial value is below twice it.
  always_comb begin
    mod_ext = {1'b0, modulus};
    dbl     = {acc, 1'b0};
    dbl_red = (dbl >= mod_ext) ? (dbl - mod_ext) : dbl;
    sum     = {1'b0, dbl_red[MOD_BITS-1:0]}
              + (b_r[MOD_BITS-1] ? {1'b0, a_r} : {(MOD_BITS+1){1'b0}});
    sum_red = (sum >= mod_ext) ? (sum - mod_ext) : sum;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start && !busy) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(MOD_BITS);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start && !busy) begin
      acc <= '0;
      a_r <= req.a;
      b_r <= req.b;
    end else if (busy) begin
      acc <= sum_red[MOD_BITS-1:0];
      b_r <= {b_r[MOD_BITS-2:0], 1'b0};
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign product   = acc;

endmodule
